@@ rtl/core/gde_pkg.sv @@
// Types, constants and elaboration-time helpers for the Gaussian density evaluator.
package gde_pkg;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } gde_in_t;

  typedef struct packed {
    logic signed [63:0] density;
    logic               saturated;
  } gde_out_t;

  typedef enum logic [2:0] {
    CfgDims      = 3'd0,
    CfgAmplitude = 3'd1,
    CfgShiftX    = 3'd2,
    CfgShiftY    = 3'd3,
    CfgShiftZ    = 3'd4,
    CfgTempX     = 3'd5,
    CfgTempY     = 3'd6,
    CfgTempZ     = 3'd7
  } cfg_reg_t;

  // Normalized mantissa (bit 63 set) times a power of two.
  typedef struct packed {
    logic [63:0]        m;
    logic signed [15:0] e;
  } xnum_t;

  localparam logic [32:0] Log2eQ32 = 33'd6196328019;
  localparam logic [63:0] Ln2Q64   = 64'hB17217F7D1CF79AB;
  localparam logic [39:0] SCap     = 40'h80_0000_0000;

  localparam xnum_t NormC1 = '{m: {31'd1713444046, 33'd0}, e: -16'sd65};
  localparam xnum_t NormC2 = '{m: {30'd683565276, 34'd0}, e: -16'sd66};

  function automatic xnum_t xn_mul_c(input xnum_t a, input xnum_t b);
    logic [127:0] p;
    xnum_t        r;
    p = {64'd0, a.m} * {64'd0, b.m};
    r.e = a.e + b.e + 16'sd64;
    if (!p[127]) begin
      r.m = p[126:63];
      r.e = r.e - 16'sd1;
    end else begin
      r.m = p[127:64];
    end
    return r;
  endfunction

  localparam xnum_t NormC3 = xn_mul_c(NormC1, NormC2);

  // Entry j of the 2^(-j/depth) table in Q1.31, from a Taylor series in Q2.62.
  function automatic logic [31:0] exp_entry(input int unsigned j, input logic [63:0] step);
    logic [63:0]  t;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] p;
    t = (step * 64'(j)) >> 2;
    term = 64'h4000_0000_0000_0000;
    sum = term;
    for (int n = 1; n <= 20; n++) begin
      p = {64'd0, term} * {64'd0, t};
      term = p[125:62] / 64'(n);
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return 32'((sum + 64'h4000_0000) >> 31);
  endfunction

endpackage

@@ rtl/core/gaussian_density_eval.sv @@
// Gaussian density evaluator: pipelined datapath plus normalization sequencer.
//
// Usage: write registers over the cfg channel (cfg_index, cfg_data) while no
// item is in flight. Each write restarts the normalization sequencer, which
// forms 1/sqrt((2pi)^d * prod T^2) * |amplitude| with a bit-serial divider
// (one quotient bit per cycle) and a shared 32x32 multiplier; in_ready stays
// low until it is done. Reset loads the default registers and runs the same
// sequence before the first item is taken.
// Items enter on in_valid/in_ready, one per cycle while no normalization runs
// and the output is not stalled, and leave on out_valid/out_ready. The depth
// is set by the per-dimension (v-shift)/T divider, 16 stages of two quotient
// bits, followed by square, sum, log2 scaling, table interpolation and the
// final normalized multiply. When the receiver stalls the whole pipeline
// holds; no item is lost or repeated, and the output register keeps its
// item until it is taken.
module gaussian_density_eval #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gde_pkg::gde_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gde_pkg::gde_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  gde_pkg::cfg_reg_t  cfg_index,
  input  logic [31:0]        cfg_data
);
  import gde_pkg::*;

  localparam int DivStages = 16;
  localparam int NumStages = DivStages + 10;
  localparam int IdxW      = $clog2(EXP_TABLE_DEPTH);
  localparam int TblW      = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [63:0] ExpStep = Ln2Q64 / 64'(EXP_TABLE_DEPTH);

  // ---------------- exp table ----------------
  logic [31:0] exp_tbl [EXP_TABLE_DEPTH + 1];
  for (genvar j = 0; j <= EXP_TABLE_DEPTH; j++) begin : g_tbl
    localparam logic [31:0] Ent = exp_entry(j, ExpStep);
    assign exp_tbl[j] = Ent;
  end

  // ---------------- registers and normalization sequencer ----------------
  typedef enum logic [3:0] {
    SqIdle, SqInit, SqRecip, SqDiv, SqDivNorm, SqMul, SqMulNorm, SqExpAdj, SqAmpShift
  } seq_state_t;

  seq_state_t         state;
  logic [1:0]         dims;
  logic [31:0]        amplitude;
  logic [31:0]        shift_x, shift_y, shift_z;
  logic [30:0]        temp_x, temp_y, temp_z;
  logic [63:0]        norm_m;
  logic signed [15:0] norm_e;
  logic [1:0]         lane;
  logic               phase_amp;
  logic [6:0]         div_n;
  logic [6:0]         div_cnt;
  logic [30:0]        div_rem;
  logic [63:0]        div_q;
  logic [63:0]        mul_a, mul_b;
  logic signed [15:0] mul_e;
  logic [127:0]       acc;
  logic [1:0]         mstep;
  logic [63:0]        am_m;
  logic signed [15:0] am_e;
  logic [63:0]        p_m;
  logic signed [15:0] p_e;
  logic               p_zero;
  logic               amp_neg;

  logic [1:0]   d_eff;
  logic [30:0]  seq_t;
  logic [31:0]  div_sh;
  logic [63:0]  mul_pp;
  logic [127:0] mul_pp_sh;
  logic [31:0]  abs_amp;
  logic [63:0]  rq_m;
  logic signed [15:0] rq_e;

  function automatic logic [30:0] eff_temp(input logic [30:0] t);
    return (t == 31'd0) ? 31'd1 : t;
  endfunction

  function automatic logic [4:0] bit_len(input logic [30:0] t);
    logic [4:0] len;
    len = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (t[i]) len = 5'(i + 1);
    end
    return len;
  endfunction

  always_comb begin
    d_eff = (dims == 2'd0) ? 2'd1 : dims;
    unique case (lane)
      2'd0:    seq_t = eff_temp(temp_x);
      2'd1:    seq_t = eff_temp(temp_y);
      default: seq_t = eff_temp(temp_z);
    endcase
    div_sh = {div_rem, (div_cnt == 7'd0)};
    mul_pp = {32'd0, (mstep[0] ? mul_a[63:32] : mul_a[31:0])} *
             {32'd0, (mstep[1] ? mul_b[63:32] : mul_b[31:0])};
    unique case (mstep)
      2'd0:    mul_pp_sh = {64'd0, mul_pp};
      2'd3:    mul_pp_sh = {mul_pp, 64'd0};
      default: mul_pp_sh = {32'd0, mul_pp, 32'd0};
    endcase
    abs_amp = amplitude[31] ? (32'd0 - amplitude) : amplitude;
    rq_m = div_q[63] ? div_q : {div_q[62:0], 1'b0};
    rq_e = -$signed({9'd0, div_n}) - $signed({15'd0, ~div_q[63]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SqInit;
      dims      <= 2'd3;
      amplitude <= 32'd65536;
      shift_x   <= '0;
      shift_y   <= '0;
      shift_z   <= '0;
      temp_x    <= 31'd65536;
      temp_y    <= 31'd65536;
      temp_z    <= 31'd65536;
    end else begin
      unique case (state)
        SqIdle: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              CfgDims:      dims      <= cfg_data[1:0];
              CfgAmplitude: amplitude <= cfg_data;
              CfgShiftX:    shift_x   <= cfg_data;
              CfgShiftY:    shift_y   <= cfg_data;
              CfgShiftZ:    shift_z   <= cfg_data;
              CfgTempX:     temp_x    <= cfg_data[30:0];
              CfgTempY:     temp_y    <= cfg_data[30:0];
              CfgTempZ:     temp_z    <= cfg_data[30:0];
            endcase
            state <= SqInit;
          end
        end
        SqInit: begin
          unique case (d_eff)
            2'd1: begin
              norm_m <= NormC1.m;
              norm_e <= NormC1.e;
            end
            2'd2: begin
              norm_m <= NormC2.m;
              norm_e <= NormC2.e;
            end
            default: begin
              norm_m <= NormC3.m;
              norm_e <= NormC3.e;
            end
          endcase
          lane      <= 2'd0;
          phase_amp <= 1'b0;
          state     <= SqRecip;
        end
        SqRecip: begin
          div_n   <= 7'd62 + {2'd0, bit_len(seq_t)};
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= '0;
          state   <= SqDiv;
        end
        SqDiv: begin
          // one quotient bit of 2^n / t per cycle
          if (div_sh >= {1'b0, seq_t}) begin
            div_rem <= 31'(div_sh - {1'b0, seq_t});
            div_q   <= {div_q[62:0], 1'b1};
          end else begin
            div_rem <= div_sh[30:0];
            div_q   <= {div_q[62:0], 1'b0};
          end
          div_cnt <= div_cnt + 7'd1;
          if (div_cnt == div_n) state <= SqDivNorm;
        end
        SqDivNorm: begin
          mul_a <= norm_m;
          mul_b <= rq_m;
          mul_e <= norm_e + rq_e + 16'sd64;
          acc   <= '0;
          mstep <= 2'd0;
          state <= SqMul;
        end
        SqMul: begin
          acc   <= acc + mul_pp_sh;
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= SqMulNorm;
        end
        SqMulNorm: begin
          if (!phase_amp) begin
            norm_m <= acc[127] ? acc[127:64] : acc[126:63];
            norm_e <= acc[127] ? mul_e : mul_e - 16'sd1;
            if (({1'b0, lane} + 3'd1) < {1'b0, d_eff}) begin
              lane  <= lane + 2'd1;
              state <= SqRecip;
            end else begin
              state <= SqExpAdj;
            end
          end else begin
            p_m   <= acc[127] ? acc[127:64] : acc[126:63];
            p_e   <= acc[127] ? mul_e : mul_e - 16'sd1;
            state <= SqIdle;
          end
        end
        SqExpAdj: begin
          norm_e  <= norm_e + $signed({10'd0, d_eff, 4'd0}) + 16'sd16;
          amp_neg <= amplitude[31];
          am_m    <= {32'd0, abs_amp};
          am_e    <= '0;
          if (abs_amp == 32'd0) begin
            p_zero <= 1'b1;
            state  <= SqIdle;
          end else begin
            p_zero <= 1'b0;
            state  <= SqAmpShift;
          end
        end
        SqAmpShift: begin
          // normalize |amplitude| one bit a cycle, then multiply into the norm
          if (am_m[63]) begin
            mul_a     <= norm_m;
            mul_b     <= am_m;
            mul_e     <= norm_e + am_e + 16'sd64;
            acc       <= '0;
            mstep     <= 2'd0;
            phase_amp <= 1'b1;
            state     <= SqMul;
          end else begin
            am_m <= {am_m[62:0], 1'b0};
            am_e <= am_e - 16'sd1;
          end
        end
        default: state <= SqIdle;
      endcase
    end
  end

  assign cfg_ready = (state == SqIdle);

  // ---------------- datapath ----------------
  logic [NumStages-1:0] vld;
  logic                 en;

  assign en        = !vld[NumStages-1] || out_ready;
  assign in_ready  = en && (state == SqIdle);
  assign out_valid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStages-2:0], in_valid && in_ready};
    end
  end

  // front: |v - shift|, cap test, lane enables
  logic [31:0] vel_l   [3];
  logic [31:0] shift_l [3];
  logic [30:0] temp_l  [3];
  logic [32:0] f_diff  [3];
  logic [32:0] f_ad    [3];
  logic [2:0]  f_cap;
  logic [2:0]  f_act;

  assign vel_l[0]   = in_data.vel_x;
  assign vel_l[1]   = in_data.vel_y;
  assign vel_l[2]   = in_data.vel_z;
  assign shift_l[0] = shift_x;
  assign shift_l[1] = shift_y;
  assign shift_l[2] = shift_z;
  assign temp_l[0]  = eff_temp(temp_x);
  assign temp_l[1]  = eff_temp(temp_y);
  assign temp_l[2]  = eff_temp(temp_z);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      f_diff[l] = {vel_l[l][31], vel_l[l]} - {shift_l[l][31], shift_l[l]};
      f_ad[l]   = f_diff[l][32] ? (33'd0 - f_diff[l]) : f_diff[l];
      f_cap[l]  = {2'd0, f_ad[l]} >= {temp_l[l], 4'd0};
      f_act[l]  = 2'(l) < d_eff;
    end
  end

  logic [30:0] dv_rem [DivStages+1][3];
  logic [31:0] dv_q   [DivStages+1][3];
  logic [3:0]  dv_lo  [DivStages+1][3];
  logic [2:0]  dv_use [DivStages+1];
  logic        dv_cap [DivStages+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        dv_rem[0][l] <= {2'd0, f_ad[l][32:4]};
        dv_lo[0][l]  <= f_ad[l][3:0];
        dv_q[0][l]   <= '0;
      end
      dv_use[0] <= f_act & ~f_cap;
      dv_cap[0] <= |(f_act & f_cap);
    end
  end

  function automatic logic [31:0] div_bit(input logic [30:0] rem, input logic b,
                                          input logic [30:0] t);
    logic [31:0] sh;
    sh = {rem, b};
    if (sh >= {1'b0, t}) return {1'b1, 31'(sh - {1'b0, t})};
    return {1'b0, sh[30:0]};
  endfunction

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    logic [31:0] st1 [3];
    logic [31:0] st2 [3];
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        st1[l] = div_bit(dv_rem[s][l], dv_lo[s][l][3], temp_l[l]);
        st2[l] = div_bit(st1[l][30:0], dv_lo[s][l][2], temp_l[l]);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          dv_rem[s+1][l] <= st2[l][30:0];
          dv_q[s+1][l]   <= {dv_q[s][l][29:0], st1[l][31], st2[l][31]};
          dv_lo[s+1][l]  <= {dv_lo[s][l][1:0], 2'b00};
        end
        dv_use[s+1] <= dv_use[s];
        dv_cap[s+1] <= dv_cap[s];
      end
    end
  end

  // square, sum, log2 scaling, table lookup and interpolation, final multiply, output
  logic [63:0] m_sq [3];
  logic [38:0] m_term [3];
  logic        m_cap;
  logic [40:0] s_sum;
  logic [39:0] s_val;
  logic [64:0] y_prod;
  logic [40:0] y_val;
  logic [31+IdxW:0] p_prod;
  logic [IdxW-1:0]  p_idx;
  logic [31:0]      p_fr;
  logic [8:0]       p_k;
  logic [TblW-1:0]  t_idx;
  logic [31:0]      t_a, t_b, t_fr;
  logic [8:0]       t_k;
  logic [63:0]      d_prod;
  logic [31:0]      d_hi, d_a;
  logic             d_ge;
  logic [8:0]       d_k;
  logic [31:0]      n_iv;
  logic [31:0]      n_ivn;
  logic signed [15:0] n_e;
  logic [63:0]      x_hi, x_lo;
  logic signed [15:0] x_e;
  logic [95:0]      z_sum;
  logic [63:0]      z_m;
  logic signed [15:0] z_e;
  logic signed [15:0] o_ne;
  logic [63:0]      o_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      m_sq[l] = {32'd0, dv_q[DivStages][l]} * {32'd0, dv_q[DivStages][l]};
    end
    s_sum  = {2'd0, m_term[0]} + {2'd0, m_term[1]} + {2'd0, m_term[2]};
    y_prod = {33'd0, s_val[39:8]} * {32'd0, Log2eQ32};
    p_prod = {IdxW'(0), y_val[31:0]} * (32 + IdxW)'(EXP_TABLE_DEPTH);
    t_idx  = TblW'(p_idx);
    d_prod = {32'd0, (t_a >= t_b) ? (t_a - t_b) : 32'd0} * {32'd0, t_fr};
    n_iv   = d_ge ? (d_a - d_hi) : d_a;
    n_ivn  = n_iv[31] ? n_iv : {n_iv[30:0], 1'b0};
    n_e    = -16'sd63 - $signed({7'd0, d_k}) - $signed({15'd0, ~n_iv[31]});
    z_sum  = {x_hi, 32'd0} + {32'd0, x_lo};
    o_ne   = 16'sd0 - z_e;
    o_q    = z_m >> o_ne[5:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        m_term[l] <= dv_use[DivStages][l] ? m_sq[l][63:25] : 39'd0;
      end
      m_cap <= dv_cap[DivStages];
      // hold S at 128 for capped or overlarge sums
      s_val <= (m_cap || s_sum > {1'b0, SCap}) ? SCap : s_sum[39:0];
      y_val <= y_prod[64:24];
      p_idx <= p_prod[31+IdxW:32];
      p_fr  <= p_prod[31:0];
      p_k   <= y_val[40:32];
      t_a   <= exp_tbl[t_idx];
      t_b   <= exp_tbl[t_idx + TblW'(1)];
      t_fr  <= p_fr;
      t_k   <= p_k;
      d_hi  <= d_prod[63:32];
      d_a   <= t_a;
      d_ge  <= t_a >= t_b;
      d_k   <= t_k;
      x_hi  <= {32'd0, p_m[63:32]} * {32'd0, n_ivn};
      x_lo  <= {32'd0, p_m[31:0]} * {32'd0, n_ivn};
      x_e   <= n_e;
      z_m   <= z_sum[95] ? z_sum[95:32] : z_sum[94:31];
      z_e   <= p_e + x_e + 16'sd64 - $signed({15'd0, ~z_sum[95]});
      priority if (p_zero) begin
        out_data.density   <= '0;
        out_data.saturated <= 1'b0;
      end else if (z_e >= 16'sd0) begin
        out_data.density   <= amp_neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        out_data.saturated <= 1'b1;
      end else if (z_e <= -16'sd64) begin
        out_data.density   <= '0;
        out_data.saturated <= 1'b0;
      end else begin
        out_data.density   <= amp_neg ? $signed(64'd0 - o_q) : $signed(o_q);
        out_data.saturated <= 1'b0;
      end
    end
  end

  // ---------------- assertions ----------------
  a_no_items_while_norm: assert property (@(posedge clk) disable iff (rst)
    (state != SqIdle) |-> (vld == '0))
    else $error("item in flight while normalization runs");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("input taken right after a register write");

  a_sat_is_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |->
      (out_data.density == 64'sh7FFF_FFFF_FFFF_FFFF ||
       out_data.density == 64'sh8000_0000_0000_0000))
    else $error("saturated flag without clipped density");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the Gaussian density evaluator.
`timescale 1ns / 1ps

module tb_top;
  import gde_pkg::*;

  typedef struct {
    logic [63:0] m;
    int          e;
  } flt_t;

  localparam logic [63:0] Ln2Frac     = 64'hB17217F7D1CF79AB;
  localparam logic [63:0] Log2eFrac   = 64'd6196328019;
  localparam logic [63:0] InvSqrt2Pi  = 64'd1713444046;
  localparam logic [63:0] Inv2Pi      = 64'd683565276;
  localparam logic [63:0] ExpArgCap   = 64'd128 << 32;
  localparam int          TableDepth  = 256;
  localparam int          IdleLimit   = 5000;
  localparam int          LongHold    = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  gde_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  gde_out_t  out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_reg_t  cfg_index = CfgDims;
  logic [31:0] cfg_data = '0;

  // register shadow and derived normalization
  logic [1:0]         reg_dims;
  logic signed [31:0] reg_amp;
  logic signed [31:0] reg_shift [3];
  logic [30:0]        reg_temp [3];
  flt_t               norm_scale;
  logic [31:0]        pow2_tbl [TableDepth + 1];

  gde_out_t pending_density [$];
  int       err_count = 0;
  int       idle_cycles = 0;
  int       hold_token = 0;
  int       burst_left = 0;

  gaussian_density_eval #(.EXP_TABLE_DEPTH(TableDepth)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------- arithmetic of the density ----------------
  function automatic flt_t flt_norm(logic [63:0] m, int e);
    flt_t r;
    r.m = m;
    r.e = e;
    if (m == 0) begin
      r.e = 0;
      return r;
    end
    while (!r.m[63]) begin
      r.m = r.m << 1;
      r.e = r.e - 1;
    end
    return r;
  endfunction

  function automatic flt_t flt_prod(flt_t a, flt_t b);
    logic [127:0] p;
    flt_t         r;
    if (a.m == 0 || b.m == 0) begin
      r.m = 0;
      r.e = 0;
      return r;
    end
    p = {64'd0, a.m} * {64'd0, b.m};
    r.e = a.e + b.e + 64;
    if (!p[127]) begin
      r.m = p[126:63];
      r.e = r.e - 1;
    end else begin
      r.m = p[127:64];
    end
    return r;
  endfunction

  function automatic logic [30:0] temp_used(logic [30:0] t);
    return (t == 0) ? 31'd1 : t;
  endfunction

  function automatic int dims_used();
    return (reg_dims == 0) ? 1 : int'(reg_dims);
  endfunction

  function automatic flt_t inverse_of(logic [30:0] t);
    int           len;
    logic [127:0] q;
    len = 0;
    while (len < 32 && ((64'(t) >> len) != 0)) len++;
    q = (128'd1 << (62 + len)) / 128'(t);
    return flt_norm(q[63:0], -(62 + len));
  endfunction

  function automatic logic [31:0] pow2_neg_entry(int j);
    logic [63:0]  step;
    logic [63:0]  t;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] p;
    step = Ln2Frac / TableDepth;
    t = (step * 64'(j)) >> 2;
    term = 64'd1 << 62;
    sum = term;
    for (int n = 1; n <= 20; n++) begin
      p = {64'd0, term} * {64'd0, t};
      term = p[125:62] / 64'(n);
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return 32'((sum + (64'd1 << 30)) >> 31);
  endfunction

  function automatic void refresh_norm();
    int   d;
    flt_t c1;
    flt_t c2;
    flt_t n;
    d = dims_used();
    c1 = flt_norm(InvSqrt2Pi, -32);
    c2 = flt_norm(Inv2Pi, -32);
    n = (d == 1) ? c1 : ((d == 2) ? c2 : flt_prod(c1, c2));
    for (int i = 0; i < d; i++) n = flt_prod(n, inverse_of(temp_used(reg_temp[i])));
    if (n.m != 0) n.e = n.e + 16 * d + 16;
    norm_scale = n;
  endfunction

  function automatic gde_out_t density_of(gde_in_t v);
    logic signed [31:0] vel [3];
    longint             diff;
    logic [63:0]        ad, t, r, s, y, k, u, p, fr, a, b, ip, absa, q;
    logic               capped, neg;
    int                 idx;
    flt_t               ex, mag;
    gde_out_t           res;
    vel[0] = v.vel_x;
    vel[1] = v.vel_y;
    vel[2] = v.vel_z;
    s = 0;
    capped = 1'b0;
    for (int i = 0; i < dims_used(); i++) begin
      diff = longint'(vel[i]) - longint'(reg_shift[i]);
      ad = (diff < 0) ? 64'(-diff) : 64'(diff);
      t = 64'(temp_used(reg_temp[i]));
      if (ad >= 16 * t) begin
        capped = 1'b1;
      end else begin
        r = (ad << 28) / t;
        s = s + ((r * r) >> 25);
      end
    end
    if (capped || s > ExpArgCap) s = ExpArgCap;
    y = ((s >> 8) * Log2eFrac) >> 24;
    k = y >> 32;
    u = y & 64'hFFFF_FFFF;
    p = u * TableDepth;
    idx = int'(p >> 32);
    if (idx >= TableDepth) idx = TableDepth - 1;
    fr = p & 64'hFFFF_FFFF;
    a = 64'(pow2_tbl[idx]);
    b = 64'(pow2_tbl[idx + 1]);
    ip = (a >= b) ? a - (((a - b) * fr) >> 32) : a;
    ex = flt_norm(ip, -31 - int'(k));
    neg = reg_amp < 0;
    absa = neg ? 64'(-longint'(reg_amp)) : 64'(longint'(reg_amp));
    mag = flt_prod(flt_prod(norm_scale, flt_norm(absa, 0)), ex);
    res.saturated = 1'b0;
    if (mag.m == 0 || mag.e <= -64) begin
      q = 0;
    end else if (mag.e >= 0) begin
      res.density = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      res.saturated = 1'b1;
      return res;
    end else begin
      q = mag.m >> (-mag.e);
    end
    res.density = neg ? -q : q;
    return res;
  endfunction

  // ---------------- result checking ----------------
  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      gde_out_t want;
      if (pending_density.size() == 0) begin
        report_mismatch($sformatf("unexpected item density=%h", out_data.density));
      end else begin
        want = pending_density.pop_front();
        if (out_data.density !== want.density)
          report_mismatch($sformatf("density %h, want %h", out_data.density, want.density));
        if (out_data.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %b, want %b",
                                    out_data.saturated, want.saturated));
      end
    end
  end

  // receiver: rotating stall pattern, plus a long hold on request
  int rx_cyc = 0;
  int rx_hold = 0;
  int rx_token = 0;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_token != hold_token) begin
      rx_token <= hold_token;
      rx_hold <= LongHold;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cyc >> 7) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= (rx_cyc % 4 == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_item(gde_in_t x);
    in_data <= x;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_density.push_back(density_of(x));
  endtask

  // bursty sender: lower valid and idle between most bursts
  task automatic send_bursty(gde_in_t x);
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    send_item(x);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_density.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    wait_drained();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgDims:      reg_dims = val[1:0];
      CfgAmplitude: reg_amp = val;
      CfgShiftX:    reg_shift[0] = val;
      CfgShiftY:    reg_shift[1] = val;
      CfgShiftZ:    reg_shift[2] = val;
      CfgTempX:     reg_temp[0] = val[30:0];
      CfgTempY:     reg_temp[1] = val[30:0];
      default:      reg_temp[2] = val[30:0];
    endcase
    refresh_norm();
  endtask

  function automatic gde_in_t pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    gde_in_t r;
    r.vel_x = x;
    r.vel_y = y;
    r.vel_z = z;
    return r;
  endfunction

  function automatic logic [31:0] rand_temp();
    logic [31:0] t;
    t = $urandom >> $urandom_range(1, 31);
    if ($urandom_range(0, 3) == 0) t = 32'd65536 << $urandom_range(0, 14);
    return t;
  endfunction

  // velocity near the configured mean, mostly within a few widths
  function automatic gde_in_t near_item();
    logic [31:0] c [3];
    longint      off;
    for (int i = 0; i < 3; i++) begin
      off = (longint'(temp_used(reg_temp[i])) * $urandom_range(0, 40)) >>> 3;
      off = off + $urandom_range(0, 255);
      if ($urandom_range(0, 1)) off = -off;
      c[i] = 32'(longint'(reg_shift[i]) + off);
    end
    return pt(c[0], c[1], c[2]);
  endfunction

  task automatic test_reset_defaults();
    send_item(pt(0, 0, 0));
    send_item(pt(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000));
    send_item(pt(32'h7FFF_FFFF, 0, 0));
    send_item(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(pt(32'h000F_FFFF, 0, 0));
  endtask

  task automatic test_dims_select();
    for (int d = 0; d < 4; d++) begin
      write_reg(CfgDims, 32'(d));
      send_item(pt(32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_item(pt(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    end
  endtask

  task automatic test_edge_settings();
    write_reg(CfgTempX, 32'd0);
    send_item(pt(0, 0, 0));
    send_item(pt(32'd1, 0, 0));
    write_reg(CfgTempX, 32'h7FFF_FFFF);
    write_reg(CfgTempY, 32'hFFFF_FFFF);
    write_reg(CfgTempZ, 32'h7FFF_FFFF);
    write_reg(CfgShiftX, 32'h8000_0000);
    write_reg(CfgShiftY, 32'h7FFF_FFFF);
    write_reg(CfgShiftZ, 32'h0000_0001);
    send_item(pt(32'h7FFF_FFFF, 32'h8000_0000, 0));
    write_reg(CfgAmplitude, 32'd0);
    send_item(pt(32'h8000_0000, 32'h7FFF_FFFF, 1));
    // tiny widths with large amplitude: overflow both signs
    write_reg(CfgTempX, 32'd1);
    write_reg(CfgTempY, 32'd1);
    write_reg(CfgTempZ, 32'd1);
    write_reg(CfgAmplitude, 32'h7FFF_FFFF);
    send_item(pt(32'h8000_0000, 32'h7FFF_FFFF, 1));
    write_reg(CfgAmplitude, 32'h8000_0000);
    send_item(pt(32'h8000_0000, 32'h7FFF_FFFF, 1));
    send_item(pt(32'h8000_0003, 32'h7FFF_FFFF, 1));
  endtask

  task automatic random_config();
    write_reg(CfgDims, $urandom_range(0, 3));
    write_reg(CfgAmplitude, ($urandom_range(0, 7) == 0) ? $urandom
                            : $urandom >> $urandom_range(0, 31));
    write_reg(CfgShiftX, $urandom);
    write_reg(CfgShiftY, $urandom >> $urandom_range(0, 31));
    write_reg(CfgShiftZ, $urandom);
    write_reg(CfgTempX, rand_temp());
    write_reg(CfgTempY, rand_temp());
    write_reg(CfgTempZ, rand_temp());
  endtask

  task automatic test_random_points();
    for (int ph = 0; ph < 9; ph++) begin
      random_config();
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 4) == 0) send_bursty(pt($urandom, $urandom, $urandom));
        else send_bursty(near_item());
      end
    end
  endtask

  task automatic test_backpressure();
    random_config();
    hold_token++;
    for (int n = 0; n < 80; n++) send_item(near_item());
    wait_drained();
    for (int n = 0; n < 20; n++) send_item(near_item());
    in_valid <= 1'b0;
  endtask

  initial begin
    reg_dims = 2'd3;
    reg_amp = 32'sd65536;
    for (int i = 0; i < 3; i++) begin
      reg_shift[i] = '0;
      reg_temp[i] = 31'd65536;
    end
    for (int j = 0; j <= TableDepth; j++) pow2_tbl[j] = pow2_neg_entry(j);
    refresh_norm();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_dims_select();
    test_edge_settings();
    test_random_points();
    test_backpressure();
    wait_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
